// ----- sv/fld_enc_pkg.sv -----
// Shared types, constants and character tables for the field layout descriptor encoder.
package fld_enc_pkg;

  localparam int NumberBits = 29;

  typedef enum logic [1:0] {
    OpStart  = 2'd0,
    OpField  = 2'd1,
    OpOneof  = 2'd2,
    OpMember = 2'd3
  } op_e;

  // Oneof phase codes; the unused code behaves as PhaseOpen.
  localparam logic [1:0] PhaseIdle   = 2'd0;
  localparam logic [1:0] PhaseOpen   = 2'd1;
  localparam logic [1:0] PhaseMember = 2'd2;

  localparam logic [6:0] RepeatedBase = 7'd20;
  localparam logic [6:0] SkipBase     = 7'd60;
  localparam logic [6:0] ModBase      = 7'd42;
  localparam logic [6:0] CharEnd      = 7'd94;   // '^'
  localparam logic [6:0] CharOneofSep = 7'd126;  // '~'
  localparam logic [6:0] CharFieldSep = 7'd124;  // '|'
  localparam logic [3:0] ModUnpacked  = 4'd1;
  localparam logic [3:0] ModProto3    = 4'd4;
  localparam logic [3:0] ModRequired  = 4'd8;

  // One queued request for the back end.
  typedef struct packed {
    logic                  err;
    logic                  has_pre;
    logic [6:0]            pre_char;
    logic                  has_dig;
    logic                  dig_six;
    logic [NumberBits-1:0] dig_val;
    logic                  has_typ;
    logic [6:0]            typ_char;
    logic                  has_mod;
    logic [6:0]            mod_char;
  } job_t;

  // 92-symbol alphabet: printable ASCII without '"', '\'' and '\\'.
  function automatic logic [6:0] alpha(input logic [6:0] idx);
    logic [6:0] ch;
    if (idx < 7'd2) begin
      ch = idx + 7'd32;
    end else if (idx < 7'd6) begin
      ch = idx + 7'd33;
    end else if (idx < 7'd58) begin
      ch = idx + 7'd34;
    end else begin
      ch = idx + 7'd35;
    end
    return ch;
  endfunction

  function automatic logic [4:0] type_code(input logic [4:0] ftype);
    logic [4:0] enc;
    unique case (ftype)
      5'd2:    enc = 5'd1;
      5'd3:    enc = 5'd9;
      5'd4:    enc = 5'd10;
      5'd5:    enc = 5'd6;
      5'd6:    enc = 5'd3;
      5'd7:    enc = 5'd2;
      5'd8:    enc = 5'd13;
      5'd9:    enc = 5'd15;
      5'd10:   enc = 5'd16;
      5'd11:   enc = 5'd17;
      5'd12:   enc = 5'd14;
      5'd13:   enc = 5'd7;
      5'd14:   enc = 5'd12;
      5'd15:   enc = 5'd4;
      5'd16:   enc = 5'd5;
      5'd17:   enc = 5'd8;
      5'd18:   enc = 5'd11;
      default: enc = 5'd0;
    endcase
    return enc;
  endfunction

endpackage

// ----- sv/fld_enc_front.sv -----
// Front end: accepts commands, tracks schema state and builds back-end requests.
module fld_enc_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         op_i,
  input  logic                               default_packed_i,
  input  logic [4:0]                         field_type_i,
  input  logic [fld_enc_pkg::NumberBits-1:0] fld_num_i,
  input  logic [3:0]                         field_flags_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output fld_enc_pkg::job_t                  q_job_o
);

  logic [fld_enc_pkg::NumberBits-1:0] prev_q, prev_d;
  logic                               pdef_q, pdef_d;
  logic [1:0]                         phase_q, phase_d;
  logic                               accept;
  logic                               in_order;
  logic [fld_enc_pkg::NumberBits:0]   prev_inc;
  logic [3:0]                         mods;
  fld_enc_pkg::job_t                  job;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign in_order   = fld_num_i > prev_q;
  assign prev_inc   = {1'b0, prev_q} + 1'b1;

  always_comb begin
    mods = 4'd0;
    if (field_flags_i[2]) mods = mods | fld_enc_pkg::ModProto3;
    if (field_flags_i[3]) mods = mods | fld_enc_pkg::ModRequired;
    if (field_flags_i[1] != pdef_q) mods = mods | fld_enc_pkg::ModUnpacked;
  end

  always_comb begin
    job          = '0;
    prev_d       = prev_q;
    pdef_d       = pdef_q;
    phase_d      = phase_q;
    q_push_o     = 1'b0;
    unique case (fld_enc_pkg::op_e'(op_i))
      fld_enc_pkg::OpStart: begin
        pdef_d  = default_packed_i;
        prev_d  = '0;
        phase_d = fld_enc_pkg::PhaseIdle;
      end
      fld_enc_pkg::OpField: begin
        q_push_o = accept;
        if (!in_order) begin
          job.err = 1'b1;
        end else begin
          prev_d       = fld_num_i;
          job.has_dig  = prev_inc != {1'b0, fld_num_i};
          job.dig_six  = 1'b0;
          job.dig_val  = fld_num_i - prev_q;
          job.has_typ  = 1'b1;
          job.typ_char = fld_enc_pkg::alpha(7'(fld_enc_pkg::type_code(field_type_i))
                         + (field_flags_i[0] ? fld_enc_pkg::RepeatedBase : 7'd0));
          job.has_mod  = mods != 4'd0;
          job.mod_char = fld_enc_pkg::alpha(fld_enc_pkg::ModBase + {3'b000, mods});
        end
      end
      fld_enc_pkg::OpOneof: begin
        q_push_o     = accept;
        job.has_pre  = 1'b1;
        job.pre_char = (phase_q == fld_enc_pkg::PhaseIdle) ? fld_enc_pkg::CharEnd
                                                          : fld_enc_pkg::CharOneofSep;
        phase_d      = fld_enc_pkg::PhaseOpen;
      end
      default: begin
        q_push_o     = accept;
        job.has_pre  = phase_q == fld_enc_pkg::PhaseMember;
        job.pre_char = fld_enc_pkg::CharFieldSep;
        job.has_dig  = 1'b1;
        job.dig_six  = 1'b1;
        job.dig_val  = fld_num_i;
        phase_d      = fld_enc_pkg::PhaseMember;
      end
    endcase
  end

  assign q_job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      pdef_q  <= 1'b0;
      phase_q <= fld_enc_pkg::PhaseIdle;
    end else if (accept) begin
      prev_q  <= prev_d;
      pdef_q  <= pdef_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ----- sv/fld_enc_queue.sv -----
// Two-entry request queue between front and back ends.
module fld_enc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fld_enc_pkg::job_t push_job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output fld_enc_pkg::job_t pop_job_o
);

  fld_enc_pkg::job_t mem_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;

  assign full_o    = cnt_q == 2'd2;
  assign empty_o   = cnt_q == 2'd0;
  assign pop_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

// ----- sv/fld_enc_back.sv -----
// Back end: expands a request into registered characters, one per cycle while not stalled.
module fld_enc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  fld_enc_pkg::job_t q_job_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [6:0]        out_char_o,
  output logic              last_char_o,
  output logic              bad_order_o
);

  logic              busy_q, busy_d;
  fld_enc_pkg::job_t job_q, job_d;
  logic              ov_q;
  logic [6:0]        char_q, char_d;
  logic              last_q, last_d;
  logic              bad_q;
  logic              advance;
  logic [fld_enc_pkg::NumberBits-1:0] nxt_val;
  logic [6:0]        dig_idx;

  assign advance = busy_q && (!ov_q || out_ready_i);
  assign q_pop_o = !busy_q && !q_empty_i;
  assign nxt_val = job_q.dig_six ? (job_q.dig_val >> 6) : (job_q.dig_val >> 5);
  assign dig_idx = job_q.dig_six ? {1'b0, job_q.dig_val[5:0]}
                                 : 7'(job_q.dig_val[4:0]) + fld_enc_pkg::SkipBase;

  always_comb begin
    job_d  = job_q;
    char_d = 7'd0;
    if (job_q.err) begin
      job_d.err = 1'b0;
    end else if (job_q.has_pre) begin
      char_d        = job_q.pre_char;
      job_d.has_pre = 1'b0;
    end else if (job_q.has_dig) begin
      char_d        = fld_enc_pkg::alpha(dig_idx);
      job_d.dig_val = nxt_val;
      job_d.has_dig = nxt_val != '0;
    end else if (job_q.has_typ) begin
      char_d        = job_q.typ_char;
      job_d.has_typ = 1'b0;
    end else begin
      char_d        = job_q.mod_char;
      job_d.has_mod = 1'b0;
    end
    last_d = !(job_d.err || job_d.has_pre || job_d.has_dig || job_d.has_typ || job_d.has_mod);
    busy_d = !last_d;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      job_q <= q_job_i;
    end else if (advance) begin
      job_q <= job_d;
    end
    if (advance) begin
      char_q <= char_d;
      last_q <= last_d;
      bad_q  <= job_q.err;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (q_pop_o) begin
        busy_q <= 1'b1;
      end else if (advance) begin
        busy_q <= busy_d;
      end
      if (advance) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_char_o  = char_q;
  assign last_char_o = last_q;
  assign bad_order_o = bad_q;

endmodule

// ----- sv/field_layout_descriptor_encoder.sv -----
// Top level of the field layout descriptor encoder.
// Schema commands enter on the slave stream and leave as base-92 characters on the master
// stream, tlast on the final character of each command. A start message command yields no
// output; a field command yields one to eight characters (up to six skip digits, a type
// character, an optional modifier); start oneof yields one; a oneof member yields up to
// six. The expander in the back end loads a queued command while idle and then sends one
// character per cycle while the output is not stalled; it loads no new command until the
// last character of the current one is registered. The front end takes a command every
// cycle while its two-entry queue has room, and keeps doing so while the output is stalled.
module field_layout_descriptor_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] default_packed, [5:1] field_type, [34:6] fld_num, [38:35] field_flags
  input  logic [39:0] s_axis_tdata,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] out_char
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  // [0] bad_order
  output logic        m_axis_tuser
);

  logic              q_full, q_empty, q_push, q_pop;
  fld_enc_pkg::job_t push_job, pop_job;
  logic [6:0]        out_char;

  fld_enc_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_axis_tvalid),
    .in_ready_o       (s_axis_tready),
    .op_i             (s_axis_tuser),
    .default_packed_i (s_axis_tdata[0]),
    .field_type_i     (s_axis_tdata[5:1]),
    .fld_num_i        (s_axis_tdata[34:6]),
    .field_flags_i    (s_axis_tdata[38:35]),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_job_o          (push_job)
  );

  fld_enc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .pop_job_o  (pop_job)
  );

  fld_enc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_job_i     (pop_job),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (out_char),
    .last_char_o (m_axis_tlast),
    .bad_order_o (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule

// ----- sv/fld_enc_chk.sv -----
// Port-level checker for the field layout descriptor encoder, with its bind.
module fld_enc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output request changed while stalled");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0))
    else $error("error request not a lone zero character");

  a_alphabet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata >= 8'd32) && (m_axis_tdata <= 8'd126)
      && (m_axis_tdata != 8'd34) && (m_axis_tdata != 8'd39) && (m_axis_tdata != 8'd92))
    else $error("character outside the alphabet");

endmodule

bind field_layout_descriptor_encoder fld_enc_chk u_fld_enc_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
